/* rtl/core/mscrc_pkg.sv */
package mscrc_pkg;

  localparam int unsigned CrcWidth   = 24;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned FmtWidth   = 5;
  localparam int unsigned MinWidth   = 4;

  localparam logic [CrcWidth-1:0]   CrcPolyReset = 24'hFFF409;
  localparam logic [MinWidth-1:0]   MinBytesReset = 4'd11;
  localparam logic [CountWidth-1:0] CountMax = 5'd31;
  localparam logic [FmtWidth-1:0]   FmtDf17 = 5'd17;
  localparam logic [FmtWidth-1:0]   FmtDf18 = 5'd18;

  // Configuration register indexes.
  localparam logic REG_CRC_POLY  = 1'b0;
  localparam logic REG_MIN_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_SHORT      = 2'd1,
    ST_CRC_FAIL   = 2'd2,
    ST_BAD_FORMAT = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [CrcWidth-1:0]   crc_residue;
    logic [FmtWidth-1:0]   downlink_format;
    logic [CountWidth-1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [CrcWidth-1:0] crc_poly;
    logic [MinWidth-1:0] min_bytes;
  } cfg_t;

  // One byte through the CRC, most significant bit first.
  function automatic logic [CrcWidth-1:0] crc_feed_byte(
    input logic [CrcWidth-1:0] crc_in,
    input logic [7:0]          data,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] crc;
    crc = crc_in ^ {data, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      if (crc[CrcWidth-1]) begin
        crc = {crc[CrcWidth-2:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[CrcWidth-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/core/mscrc_frame.sv */
module mscrc_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mscrc_pkg::in_item_t item_i,
  input  mscrc_pkg::cfg_t     cfg_i,
  output mscrc_pkg::out_item_t result_o
);
  import mscrc_pkg::*;

  logic [CrcWidth-1:0]   crc_q, crc_d, crc_now;
  logic [CountWidth-1:0] count_q, count_d, count_now;
  logic [FmtWidth-1:0]   fmt_q, fmt_d, fmt_now;
  status_e               status;

  always_comb begin
    fmt_now   = (count_q == '0) ? item_i.data_byte[7:3] : fmt_q;
    crc_now   = crc_feed_byte(crc_q, item_i.data_byte, cfg_i.crc_poly);
    count_now = (count_q == CountMax) ? CountMax : count_q + 1'b1;

    // Too short wins over a bad CRC, which wins over a wrong format.
    if (count_now < {1'b0, cfg_i.min_bytes}) begin
      status = ST_SHORT;
    end else if (crc_now != '0) begin
      status = ST_CRC_FAIL;
    end else if (fmt_now != FmtDf17 && fmt_now != FmtDf18) begin
      status = ST_BAD_FORMAT;
    end else begin
      status = ST_GOOD;
    end

    result_o.status          = status;
    result_o.crc_residue     = crc_now;
    result_o.downlink_format = fmt_now;
    result_o.byte_count      = count_now;
  end

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    fmt_d   = fmt_q;
    if (step_i) begin
      fmt_d = fmt_now;
      if (item_i.last_byte) begin
        crc_d   = '0;
        count_d = '0;
      end else begin
        crc_d   = crc_now;
        count_d = count_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      count_q <= '0;
      fmt_q   <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      fmt_q   <= fmt_d;
    end
  end

endmodule

/* rtl/core/mscrc_out_reg.sv */
module mscrc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mscrc_pkg::out_item_t result_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mscrc_pkg::out_item_t out_item_o
);
  import mscrc_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  // A new result may replace one that is being taken in the same cycle.
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/core/mode_s_crc24_frame_check_core.sv */
// A byte is taken into the input register; once it advances, the result of a frame's last
// byte is registered in the output register.
// Throughput: one byte per cycle; the byte-wide CRC network sits between the input
// register and the output register. Only a last byte waits, while the output register is full and stalled.
// Reset clears the frame state and valid flags; configuration returns to 0xFFF409, 11.
module mode_s_crc24_frame_check_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mscrc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mscrc_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [23:0]          cfg_wdata_i
);
  import mscrc_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      s1_adv;
  logic      in_accept;
  out_item_t result;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CRC_POLY:  cfg_d.crc_poly  = cfg_wdata_i;
        REG_MIN_BYTES: cfg_d.min_bytes = cfg_wdata_i[MinWidth-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_poly  <= CrcPolyReset;
      cfg_q.min_bytes <= MinBytesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A byte without the last mark never needs the output register.
  assign s1_adv = s1_valid_q & (~s1_item_q.last_byte | ~out_valid_o | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_accept | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  mscrc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  mscrc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv & s1_item_q.last_byte),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // The input register only holds when a finished frame result is blocked.
  a_hold_only_on_blocked_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (s1_item_q.last_byte && out_valid_o && out_stall_i))
    else $error("input register held without a blocked result");

  a_result_from_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_item_q.last_byte))
    else $error("result appeared without a last byte");

  a_good_means_zero_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_GOOD) |-> (out_item_o.crc_residue == '0))
    else $error("good status with nonzero residue");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.byte_count != '0))
    else $error("result with zero byte count");

endmodule
